FILE: rtl/p2sca_pkg.sv
// ----------------------------------------------------------------------------
// p2sca_pkg: shared types and constants of the size-class allocator
// Holds the channel item structs, the front-to-back queue entry, the
// operation codes, the default parameter values and the class helper.
// ----------------------------------------------------------------------------
package p2sca_pkg;

  // Default configuration values.
  localparam int NumClassesDefault   = 16;
  localparam int MinClassDefault     = 2;
  localparam int RefillCountDefault  = 10;
  localparam int PoolAddrBitsDefault = 16;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Width of a class number, wide enough for a bit length of 32.
  localparam int ClassW = 6;

  // Counter width of the per-class statistics.
  localparam int CntW = 15;

  // Request item.
  typedef struct packed {
    logic        op;
    logic [15:0] count;
    logic [15:0] size_bytes;
    logic [15:0] block_addr;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [15:0]     addr;
    logic            fail;
    logic [3:0]      class_index;
    logic [31:0]     bytes_outstanding;
    logic [CntW-1:0] taken_count;
    logic [CntW-1:0] free_count;
  } rsp_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic              op;
    logic [31:0]       bytes;
    logic [ClassW-1:0] cls;
    logic              oversize;
    logic [15:0]       block_addr;
  } qent_t;

  // Number of significant bits in a 32-bit value.
  function automatic logic [ClassW-1:0] bit_length(input logic [31:0] v);
    logic [ClassW-1:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = ClassW'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

FILE: rtl/p2sca_front.sv
// ----------------------------------------------------------------------------
// p2sca_front: request intake and size classification
// Registers the request size (the element product on an allocate), then
// rounds it to its power-of-two class and pushes the item to the queue.
// ----------------------------------------------------------------------------
module p2sca_front #(
  parameter int NUM_CLASSES = p2sca_pkg::NumClassesDefault,
  parameter int MIN_CLASS   = p2sca_pkg::MinClassDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  p2sca_pkg::req_t   req,
  output logic              push,
  output p2sca_pkg::qent_t  push_item,
  input  logic              full
);

  logic        s1_valid;
  logic        s1_op;
  logic [31:0] s1_bytes;
  logic [15:0] s1_addr;
  logic        accept;
  logic [31:0] product;
  logic [p2sca_pkg::ClassW-1:0] raw_cls;
  logic [p2sca_pkg::ClassW-1:0] cls;

  // The stage holds its item while the queue is full.
  assign req_stall = s1_valid && full;
  assign accept    = req_valid && !req_stall;
  assign push      = s1_valid && !full;

  // Requested bytes: the element product on an allocate, the size on a free.
  assign product = 32'(req.count) * 32'(req.size_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= req.op;
      s1_bytes <= (req.op == p2sca_pkg::OP_ALLOC) ? product : 32'(req.size_bytes);
      s1_addr  <= req.block_addr;
    end
  end

  // Round up to a power of two, with a floor at the smallest class.
  always_comb begin
    raw_cls = (s1_bytes > 32'd1) ? p2sca_pkg::bit_length(s1_bytes - 32'd1) : '0;
    cls     = (raw_cls < p2sca_pkg::ClassW'(MIN_CLASS)) ?
              p2sca_pkg::ClassW'(MIN_CLASS) : raw_cls;
    push_item.op         = s1_op;
    push_item.bytes      = s1_bytes;
    push_item.cls        = cls;
    push_item.oversize   = (cls >= p2sca_pkg::ClassW'(NUM_CLASSES));
    push_item.block_addr = s1_addr;
  end

endmodule

FILE: rtl/p2sca_fifo.sv
// ----------------------------------------------------------------------------
// p2sca_fifo: two-entry queue between the front and the back
// Lets the front keep classifying while the back works through a refill.
// ----------------------------------------------------------------------------
module p2sca_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  p2sca_pkg::qent_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output p2sca_pkg::qent_t  item
);

  p2sca_pkg::qent_t entries [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign item  = entries[rptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

endmodule

FILE: rtl/p2sca_back.sv
// ----------------------------------------------------------------------------
// p2sca_back: free-list engine and result register
// Pops and pushes the per-class free stacks through the link memory,
// carves refill runs from the bump pointer and keeps the statistics.
// ----------------------------------------------------------------------------
module p2sca_back #(
  parameter int NUM_CLASSES    = p2sca_pkg::NumClassesDefault,
  parameter int REFILL_COUNT   = p2sca_pkg::RefillCountDefault,
  parameter int POOL_ADDR_BITS = p2sca_pkg::PoolAddrBitsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  p2sca_pkg::qent_t  q_item,
  output logic              q_pop,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output p2sca_pkg::rsp_t   rsp
);

  localparam int AW     = POOL_ADDR_BITS;
  localparam int HW     = AW + 1;
  localparam int LW     = AW - 2;
  localparam int LD     = 1 << LW;
  localparam int CW     = $clog2(NUM_CLASSES);
  localparam int RC_W   = $clog2(REFILL_COUNT + 1);
  localparam int NEED_W = 33 + RC_W;
  localparam int CNW    = p2sca_pkg::CntW;

  localparam logic [NEED_W-1:0] POOL_END  = NEED_W'(1) << AW;
  localparam logic [HW-1:0]     NULL_HEAD = HW'(1) << AW;

  localparam logic [1:0] ST_EXEC   = 2'd0;
  localparam logic [1:0] ST_REFILL = 2'd1;
  localparam logic [1:0] ST_POP    = 2'd2;

  logic [1:0]     state;
  logic [1:0]     state_next;
  logic [HW-1:0]  head   [NUM_CLASSES];
  logic [CNW-1:0] taken  [NUM_CLASSES];
  logic [CNW-1:0] freec  [NUM_CLASSES];
  logic [HW-1:0]  bump;
  logic [31:0]    total;
  logic [HW-1:0]  cursor;
  logic [RC_W-1:0] fill_cnt;
  logic [HW-1:0]  link_mem [LD];
  logic [HW-1:0]  rdata;

  logic [CW-1:0]  ci;
  logic [HW-1:0]  head_c;
  logic [HW-1:0]  size_c;
  logic [NEED_W-1:0] need;
  logic           fits;
  logic           slot_free;
  logic           last;
  logic           work;
  logic           is_alloc;
  logic [AW-1:0]  baddr;
  logic           do_over;
  logic           do_free;
  logic           do_read;
  logic           do_start;
  logic           do_nofit;
  logic           do_fill;
  logic           do_pop;
  logic           emit;
  logic           mem_we;
  logic [LW-1:0]  mem_addr;
  logic [HW-1:0]  mem_wdata;
  logic [HW-1:0]  cursor_step;
  p2sca_pkg::rsp_t rsp_next;

  // Decode of the item at the queue head.
  assign ci        = q_item.cls[CW-1:0];
  assign head_c    = head[ci];
  assign size_c    = HW'(1) << q_item.cls;
  assign need      = NEED_W'(REFILL_COUNT) << q_item.cls;
  assign fits      = (NEED_W'(bump) + need) <= POOL_END;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign last      = (fill_cnt == RC_W'(REFILL_COUNT - 1));
  assign baddr     = AW'(q_item.block_addr);
  assign work      = (state == ST_EXEC) && q_valid;
  assign is_alloc  = (q_item.op == p2sca_pkg::OP_ALLOC);
  assign cursor_step = cursor + size_c;

  // Actions of this cycle.
  assign do_over  = work && q_item.oversize && slot_free;
  assign do_free  = work && !q_item.oversize && !is_alloc && slot_free;
  assign do_read  = work && !q_item.oversize && is_alloc && !head_c[AW];
  assign do_start = work && !q_item.oversize && is_alloc && head_c[AW] && fits;
  assign do_nofit = work && !q_item.oversize && is_alloc && head_c[AW] && !fits &&
                    slot_free;
  assign do_fill  = (state == ST_REFILL);
  assign do_pop   = (state == ST_POP) && slot_free;
  assign emit     = do_over || do_free || do_nofit || do_pop;
  assign q_pop    = emit;

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_EXEC: begin
        if (do_read) begin
          state_next = ST_POP;
        end else if (do_start) begin
          state_next = ST_REFILL;
        end
      end
      ST_REFILL: begin
        if (last) begin
          state_next = ST_EXEC;
        end
      end
      ST_POP: begin
        if (do_pop) begin
          state_next = ST_EXEC;
        end
      end
      default: begin
        state_next = ST_EXEC;
      end
    endcase
  end

  // Link memory port: refill and free write, a pop reads.
  always_comb begin
    mem_we    = do_free || do_fill;
    mem_addr  = head_c[AW-1:2];
    mem_wdata = head_c;
    if (do_fill) begin
      mem_addr  = cursor[AW-1:2];
      mem_wdata = last ? NULL_HEAD : cursor_step;
    end else if (do_free) begin
      mem_addr = baddr[AW-1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_addr] <= mem_wdata;
    end
    if (do_read) begin
      rdata <= link_mem[mem_addr];
    end
  end

  // Result of the finishing item.
  always_comb begin
    rsp_next.addr              = do_pop ? 16'(head_c[AW-1:0]) : 16'd0;
    rsp_next.fail              = do_over || do_nofit;
    rsp_next.class_index       = do_over ? 4'd0 : q_item.cls[3:0];
    rsp_next.bytes_outstanding = total;
    rsp_next.taken_count       = taken[ci];
    rsp_next.free_count        = freec[ci];
    if (do_over) begin
      rsp_next.taken_count = '0;
      rsp_next.free_count  = '0;
    end else if (do_free) begin
      rsp_next.bytes_outstanding = total - q_item.bytes;
      rsp_next.taken_count       = taken[ci] - CNW'(1);
      rsp_next.free_count        = freec[ci] + CNW'(1);
    end else if (do_pop) begin
      rsp_next.bytes_outstanding = total + q_item.bytes;
      rsp_next.taken_count       = taken[ci] + CNW'(1);
      rsp_next.free_count        = freec[ci] - CNW'(1);
    end
  end

  // Control state, stack heads and statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_EXEC;
      bump      <= '0;
      total     <= '0;
      rsp_valid <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        head[k]  <= NULL_HEAD;
        taken[k] <= '0;
        freec[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (do_free) begin
        head[ci]  <= {1'b0, baddr};
        taken[ci] <= rsp_next.taken_count;
        freec[ci] <= rsp_next.free_count;
        total     <= rsp_next.bytes_outstanding;
      end
      if (do_fill && last) begin
        head[ci]  <= bump;
        bump      <= cursor_step;
        freec[ci] <= freec[ci] + CNW'(REFILL_COUNT);
      end
      if (do_pop) begin
        head[ci]  <= rdata;
        taken[ci] <= rsp_next.taken_count;
        freec[ci] <= rsp_next.free_count;
        total     <= rsp_next.bytes_outstanding;
      end
    end
  end

  // Refill cursor and result payload.
  always_ff @(posedge clk) begin
    if (do_start) begin
      cursor   <= bump;
      fill_cnt <= '0;
    end else if (do_fill) begin
      cursor   <= cursor_step;
      fill_cnt <= fill_cnt + RC_W'(1);
    end
    if (emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: rtl/pow2_size_class_allocator.sv
// ----------------------------------------------------------------------------
// Path: a free passes the front register, a queue entry and the result
// register; an allocate adds the refill on an empty stack, the link-memory
// read and the pop state. One free per cycle while the result is not
// stalled; an allocate holds the back until its pop. No clearing pass: the
// block takes items the cycle after rst falls; rst empties all stacks.
// ----------------------------------------------------------------------------
// pow2_size_class_allocator: power-of-two size-class allocator
// Front classifies each request, a short queue decouples it from the back,
// which serves the per-class free stacks over a byte pool.
// ----------------------------------------------------------------------------
module pow2_size_class_allocator #(
  parameter int NUM_CLASSES    = p2sca_pkg::NumClassesDefault,
  parameter int MIN_CLASS      = p2sca_pkg::MinClassDefault,
  parameter int REFILL_COUNT   = p2sca_pkg::RefillCountDefault,
  parameter int POOL_ADDR_BITS = p2sca_pkg::PoolAddrBitsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  p2sca_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output p2sca_pkg::rsp_t  rsp
);

  logic             push;
  logic             full;
  logic             q_valid;
  logic             q_pop;
  p2sca_pkg::qent_t push_item;
  p2sca_pkg::qent_t q_item;

  p2sca_front #(
    .NUM_CLASSES (NUM_CLASSES),
    .MIN_CLASS   (MIN_CLASS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  p2sca_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (q_pop),
    .valid     (q_valid),
    .item      (q_item)
  );

  p2sca_back #(
    .NUM_CLASSES    (NUM_CLASSES),
    .REFILL_COUNT   (REFILL_COUNT),
    .POOL_ADDR_BITS (POOL_ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
